### rtl/kpm_pkg.sv
`timescale 1ns / 1ps
package kpm_pkg;

  localparam int unsigned CfgWidth = 16;

  localparam logic [0:0] REG_DEBOUNCE = 1'b0;
  localparam logic [0:0] REG_IDLE     = 1'b1;

  localparam logic [CfgWidth-1:0] DEBOUNCE_RESET = 16'd2;
  localparam logic [CfgWidth-1:0] IDLE_RESET     = 16'd1000;

  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;
  localparam logic [3:0] NO_KEY   = 4'd15;

  localparam logic [6:0] CHR_EMPTY = 7'h25;
  localparam logic [6:0] CHR_STAR  = 7'h2A;
  localparam logic [6:0] CHR_HASH  = 7'h23;

  localparam logic [2:0] TAP_WRAP = 3'd5;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_event;
    logic [3:0] key_code;
    logic [6:0] text_char;
    logic [2:0] tap_count;
  } kpm_result_t;

  function automatic logic [3:0] kpm_key_map(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] key;
    key = 4'd0;
    unique case ({row, col})
      4'b00_00: key = 4'd1;
      4'b00_01: key = 4'd2;
      4'b01_00: key = KEY_STAR;
      4'b01_01: key = 4'd0;
      4'b01_10: key = KEY_HASH;
      4'b10_00: key = 4'd7;
      4'b10_01: key = 4'd8;
      4'b10_10: key = 4'd9;
      4'b11_00: key = 4'd4;
      4'b11_01: key = 4'd5;
      4'b11_10: key = 4'd6;
      default:  key = 4'd3;
    endcase
    return key;
  endfunction

  // Letters of one digit key, slot 0 in the low bits.
  function automatic logic [34:0] kpm_letter_row(input logic [3:0] key);
    logic [34:0] row;
    row = {5{CHR_EMPTY}};
    unique case (key)
      4'd0:    row = {CHR_EMPTY, CHR_EMPTY, CHR_EMPTY, 7'h20, 7'h30};
      4'd1:    row = {CHR_EMPTY, CHR_EMPTY, CHR_EMPTY, CHR_EMPTY, 7'h31};
      4'd2:    row = {CHR_EMPTY, 7'h32, 7'h43, 7'h42, 7'h41};
      4'd3:    row = {CHR_EMPTY, 7'h33, 7'h46, 7'h45, 7'h44};
      4'd4:    row = {CHR_EMPTY, 7'h34, 7'h49, 7'h48, 7'h47};
      4'd5:    row = {CHR_EMPTY, 7'h35, 7'h4C, 7'h4B, 7'h4A};
      4'd6:    row = {CHR_EMPTY, 7'h36, 7'h4F, 7'h4E, 7'h4D};
      4'd7:    row = {7'h37, 7'h53, 7'h52, 7'h51, 7'h50};
      4'd8:    row = {CHR_EMPTY, 7'h38, 7'h56, 7'h55, 7'h54};
      4'd9:    row = {7'h39, 7'h5A, 7'h59, 7'h58, 7'h57};
      default: row = {5{CHR_EMPTY}};
    endcase
    return row;
  endfunction

  function automatic logic [6:0] kpm_letter(input logic [3:0] key, input logic [2:0] slot);
    logic [34:0] row;
    logic [6:0]  chr;
    row = kpm_letter_row(key);
    chr = row[6:0];
    unique case (slot)
      3'd1:    chr = row[13:7];
      3'd2:    chr = row[20:14];
      3'd3:    chr = row[27:21];
      3'd4:    chr = row[34:28];
      default: chr = row[6:0];
    endcase
    return chr;
  endfunction

endpackage

### rtl/keypad_scan_multitap_unit.sv
`timescale 1ns / 1ps
// An accepted item's result is registered in the result buffer's head or skid entry.
// Throughput: one item per cycle while in_ready is high; the two-entry result buffer keeps
// taking items while a result waits, so in_ready drops only when both entries are full.
// Reset is synchronous and active low: scanning from row 0, multi-tap memory empty,
// debounce_ticks 2, idle_ticks 1000, result buffer empty.
module keypad_scan_multitap_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [kpm_pkg::CfgWidth-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_col_lines,
  input  logic                         in_tick,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   out_row_drive,
  output logic                         out_key_event,
  output logic [3:0]                   out_key_code,
  output logic [6:0]                   out_text_char,
  output logic [2:0]                   out_tap_count
);
  import kpm_pkg::*;

  kpm_result_t res;
  kpm_result_t head_r, head_nxt;
  kpm_result_t skid_r, skid_nxt;
  logic        head_vld_r, head_vld_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  logic        push, pop;

  assign in_ready = !skid_vld_r;
  assign push     = in_valid && in_ready;
  assign pop      = head_vld_r && out_ready;

  kpm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (push),
    .col_lines (in_col_lines),
    .tick      (in_tick),
    .res       (res)
  );

  always_comb begin
    head_nxt     = head_r;
    head_vld_nxt = head_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (!head_vld_r || pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_vld_nxt = push;
        skid_nxt     = res;
      end else begin
        head_nxt     = res;
        head_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = head_vld_r;
  assign out_row_drive = head_r.row_drive;
  assign out_key_event = head_r.key_event;
  assign out_key_code  = head_r.key_code;
  assign out_text_char = head_r.text_char;
  assign out_tap_count = head_r.tap_count;

endmodule

### rtl/kpm_core.sv
`timescale 1ns / 1ps
module kpm_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [kpm_pkg::CfgWidth-1:0] cfg_data,
  input  logic                         step,
  input  logic [2:0]                   col_lines,
  input  logic                         tick,
  output kpm_pkg::kpm_result_t         res
);
  import kpm_pkg::*;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_DECODE   = 2'd2,
    PH_RELEASE  = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [1:0]          row_r, row_nxt;
  logic [1:0]          col_r, col_nxt;
  logic [15:0]         tick_cnt_r, tick_cnt_nxt;
  logic [2:0]          tap_r, tap_nxt;
  logic                rot_r, rot_nxt;
  logic [3:0]          last_key_r, last_key_nxt;
  logic [CfgWidth-1:0] debounce_r, idle_r;

  logic [15:0] tc;
  logic        pressed;
  logic [1:0]  col_sel;
  logic [3:0]  key;
  logic [2:0]  tap_inc;
  logic [2:0]  slot;
  logic [6:0]  chr_raw;

  assign pressed  = (col_lines != 3'b111);
  assign tc       = tick_cnt_r + {15'd0, (tick && (tick_cnt_r != 16'hFFFF))};
  assign col_sel  = (col_r > 2'd2) ? 2'd2 : col_r;
  assign key      = kpm_key_map(row_r, col_sel);
  assign tap_inc  = (key == last_key_r) ? (tap_r + 3'd1) : tap_r;
  assign slot     = (tap_inc >= TAP_WRAP) ? (tap_inc - TAP_WRAP) : tap_inc;
  assign chr_raw  = kpm_letter(key, slot);

  always_comb begin
    phase_nxt     = phase_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    tick_cnt_nxt  = tc;
    tap_nxt       = tap_r;
    rot_nxt       = rot_r;
    last_key_nxt  = last_key_r;
    res.key_event = 1'b0;
    res.key_code  = 4'd0;
    res.text_char = 7'd0;
    unique case (phase_r)
      PH_SCAN: begin
        if (tc > idle_r) begin
          tap_nxt      = 3'd0;
          rot_nxt      = 1'b0;
          last_key_nxt = NO_KEY;
          tick_cnt_nxt = 16'd0;
        end
        if (pressed) begin
          phase_nxt    = PH_DEBOUNCE;
          tick_cnt_nxt = 16'd0;
        end else begin
          row_nxt = row_r + 2'd1;
        end
      end
      PH_DEBOUNCE: begin
        if (tc > debounce_r) begin
          if (pressed) begin
            priority if (!col_lines[0]) col_nxt = 2'd0;
            else if (!col_lines[1])     col_nxt = 2'd1;
            else                        col_nxt = 2'd2;
            phase_nxt = PH_DECODE;
          end else begin
            phase_nxt = PH_SCAN;
          end
        end
      end
      PH_DECODE: begin
        last_key_nxt  = key;
        tap_nxt       = tap_inc;
        res.key_event = 1'b1;
        res.key_code  = key;
        priority if (key == KEY_STAR) begin
          res.text_char = CHR_STAR;
        end else if (key == KEY_HASH) begin
          res.text_char = CHR_HASH;
        end else if (chr_raw == CHR_EMPTY || tap_inc == TAP_WRAP) begin
          rot_nxt       = 1'b1;
          tap_nxt       = 3'd0;
          res.text_char = kpm_letter(key, 3'd0);
        end else begin
          res.text_char = chr_raw;
        end
        phase_nxt = PH_RELEASE;
      end
      default: begin
        if (!pressed) begin
          tick_cnt_nxt = 16'd0;
          phase_nxt    = PH_SCAN;
        end
      end
    endcase
    res.row_drive = ~(4'b0001 << (row_nxt + 2'd1));
    res.tap_count = tap_nxt + {1'b0, rot_nxt, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SCAN;
      row_r      <= 2'd0;
      col_r      <= 2'd0;
      tick_cnt_r <= 16'd0;
      tap_r      <= 3'd0;
      rot_r      <= 1'b0;
      last_key_r <= NO_KEY;
      debounce_r <= DEBOUNCE_RESET;
      idle_r     <= IDLE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE: debounce_r <= cfg_data;
          default:      idle_r     <= cfg_data;
        endcase
      end
      if (step) begin
        phase_r    <= phase_nxt;
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        tick_cnt_r <= tick_cnt_nxt;
        tap_r      <= tap_nxt;
        rot_r      <= rot_nxt;
        last_key_r <= last_key_nxt;
      end
    end
  end

endmodule

### rtl/kpm_checker.sv
`timescale 1ns / 1ps
module kpm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_row_drive,
  input logic       out_key_event,
  input logic [3:0] out_key_code,
  input logic [6:0] out_text_char
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Exactly one row is driven low in every result.
  a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(~out_row_drive))
    else $error("row drive is not one-hot active low");

  // Steps without a decoded key carry neither a code nor a character.
  a_quiet_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_event |-> out_key_code == 4'd0 && out_text_char == 7'd0)
    else $error("key fields set without a key event");

  // A decoded key is a real key and always has a character.
  a_key_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_event |-> out_key_code <= 4'd11 && out_text_char != 7'd0)
    else $error("decoded key out of range or without a character");

endmodule

bind keypad_scan_multitap_unit kpm_checker u_kpm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row_drive (out_row_drive),
  .out_key_event (out_key_event),
  .out_key_code  (out_key_code),
  .out_text_char (out_text_char)
);
